// ----- src/eai_pkg.sv -----
// ----------------------------------------------------------------------------
// eai_pkg
// Shared types for the edge attribute interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package eai_pkg;

    // control bits that travel with each item down the pipeline
    typedef struct packed {
        logic valid;
        logic point;   // both endpoints on one pixel
        logic neg;     // sign of the product L * (V1 - V2)
    } t_ctl;

endpackage

`default_nettype wire

// ----- src/edge_attribute_interpolator.sv -----
// ----------------------------------------------------------------------------
// edge_attribute_interpolator
// Linear interpolation of an edge attribute at a query pixel, rounded and
// saturated, with a depth pick when both endpoints share a pixel.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy is always low. The restoring divider
// retires one quotient bit per pipeline stage.
// Reset clears only the valid bits of the pipeline; the receiver cannot stall.
`default_nettype none

module edge_attribute_interpolator #(
    parameter int COORD_BITS = 13,
    parameter int VALUE_BITS = 24
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire signed [COORD_BITS-1:0]  i_a_x,
    input  wire signed [COORD_BITS-1:0]  i_a_y,
    input  wire signed [VALUE_BITS-1:0]  i_a_depth,
    input  wire signed [COORD_BITS-1:0]  i_b_x,
    input  wire signed [COORD_BITS-1:0]  i_b_y,
    input  wire signed [VALUE_BITS-1:0]  i_b_depth,
    input  wire signed [COORD_BITS-1:0]  i_query_x,
    input  wire signed [COORD_BITS-1:0]  i_query_y,
    input  wire signed [VALUE_BITS-1:0]  i_value_a,
    input  wire signed [VALUE_BITS-1:0]  i_value_b,
    output logic                         o_done,
    output logic signed [VALUE_BITS-1:0] o_result_value,
    output logic                         o_point_edge,
    output logic                         o_clipped
);

    localparam int CW = COORD_BITS;
    localparam int VW = VALUE_BITS;
    localparam int DW = CW + 1;          // coordinate difference
    localparam int NW = DW + VW + 1;     // signed product
    localparam int QW = CW + VW + 1;     // dividend / quotient magnitude
    localparam int TW = CW;              // span, always below 2**CW
    localparam int RW = QW + 2;          // final sum

    localparam logic signed [RW-1:0] VMAX = RW'((64'sd1 <<< (VW - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] VMIN = -VMAX - RW'(1);

    assign busy = 1'b0;

    // ---------------- stage 0: input capture ----------------
    logic                  r0_valid;
    logic signed [CW-1:0]  r0_ax, r0_ay, r0_bx, r0_by, r0_qx, r0_qy;
    logic signed [VW-1:0]  r0_ad, r0_bd, r0_va, r0_vb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= start;
        end
        r0_ax <= i_a_x;     r0_ay <= i_a_y;     r0_ad <= i_a_depth;
        r0_bx <= i_b_x;     r0_by <= i_b_y;     r0_bd <= i_b_depth;
        r0_qx <= i_query_x; r0_qy <= i_query_y;
        r0_va <= i_value_a; r0_vb <= i_value_b;
    end

    // ---------------- stage 1: ordering, span, offset ----------------
    logic                  n1_point;
    logic [TW-1:0]         n1_total;
    logic signed [DW-1:0]  n1_len;
    logic signed [VW:0]    n1_vdiff;
    logic signed [VW-1:0]  n1_v2, n1_pval;

    always_comb begin
        logic signed [CW-1:0] x1, y1, x2, y2;
        logic signed [VW-1:0] v1, v2;
        logic signed [DW-1:0] dx, dy, adx;
        logic                 xmaj;
        x1 = r0_ax; y1 = r0_ay; x2 = r0_bx; y2 = r0_by;
        v1 = r0_va; v2 = r0_vb;
        n1_point = (r0_ax == r0_bx) && (r0_ay == r0_by);
        n1_pval  = (r0_ad > r0_bd) ? r0_va : r0_vb;
        if (y1 > y2) begin
            x1 = r0_bx; x2 = r0_ax;
            y1 = r0_by; y2 = r0_ay;
            v1 = r0_vb; v2 = r0_va;
        end
        dx   = DW'(x2) - DW'(x1);
        dy   = DW'(y2) - DW'(y1);
        adx  = dx[DW-1] ? -dx : dx;
        xmaj = (dx != '0) && (dy < adx);
        if (xmaj && (x1 > x2)) begin
            {x1, x2} = {x2, x1};
            {v1, v2} = {v2, v1};
        end
        if (xmaj) begin
            n1_total = TW'(DW'(x2) - DW'(x1));
            n1_len   = DW'(x2) - DW'(r0_qx);
        end else begin
            n1_total = TW'(DW'(y2) - DW'(y1));
            n1_len   = DW'(y2) - DW'(r0_qy);
        end
        if (n1_point) begin
            n1_total = TW'(1);   // keeps the divider defined
        end
        n1_vdiff = (VW+1)'(v1) - (VW+1)'(v2);
        n1_v2    = v2;
    end

    logic                  r1_valid, r1_point;
    logic [TW-1:0]         r1_total;
    logic signed [DW-1:0]  r1_len;
    logic signed [VW:0]    r1_vdiff;
    logic signed [VW-1:0]  r1_v2, r1_pval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= r0_valid;
        end
        r1_point <= n1_point; r1_total <= n1_total; r1_len <= n1_len;
        r1_vdiff <= n1_vdiff; r1_v2 <= n1_v2; r1_pval <= n1_pval;
    end

    // ---------------- stage 2: product ----------------
    logic                  r2_valid, r2_point;
    logic [TW-1:0]         r2_total;
    logic signed [NW-1:0]  r2_num;
    logic signed [VW-1:0]  r2_v2, r2_pval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_point <= r1_point; r2_total <= r1_total;
        r2_num   <= NW'(r1_len) * NW'(r1_vdiff);
        r2_v2    <= r1_v2;    r2_pval  <= r1_pval;
    end

    // ---------------- stage 3: magnitude plus half span ----------------
    logic signed [NW-1:0]  n3_abs;
    assign n3_abs = r2_num[NW-1] ? -r2_num : r2_num;

    eai_pkg::t_ctl         r_ctl   [0:QW];
    logic [TW-1:0]         r_tot   [0:QW];
    logic [TW-1:0]         r_rem   [0:QW];
    logic [QW-1:0]         r_dq    [0:QW];
    logic signed [VW-1:0]  r_v2    [0:QW];
    logic signed [VW-1:0]  r_pval  [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0].valid <= 1'b0;
        end else begin
            r_ctl[0].valid <= r2_valid;
        end
        r_ctl[0].point <= r2_point;
        r_ctl[0].neg   <= r2_num[NW-1];
        r_tot[0]  <= r2_total;
        r_rem[0]  <= '0;
        r_dq[0]   <= n3_abs[QW-1:0] + QW'(r2_total >> 1);
        r_v2[0]   <= r2_v2;
        r_pval[0] <= r2_pval;
    end

    // ---------------- divider: one quotient bit per stage ----------------
    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [TW:0] n_part;
        logic [TW:0] n_diff;
        logic        n_qbit;
        assign n_part = {r_rem[k], r_dq[k][QW-1]};
        assign n_diff = n_part - {1'b0, r_tot[k]};
        assign n_qbit = (n_part >= {1'b0, r_tot[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k+1].valid <= 1'b0;
            end else begin
                r_ctl[k+1].valid <= r_ctl[k].valid;
            end
            r_ctl[k+1].point <= r_ctl[k].point;
            r_ctl[k+1].neg   <= r_ctl[k].neg;
            r_tot[k+1]  <= r_tot[k];
            r_rem[k+1]  <= n_qbit ? n_diff[TW-1:0] : n_part[TW-1:0];
            r_dq[k+1]   <= {r_dq[k][QW-2:0], n_qbit};
            r_v2[k+1]   <= r_v2[k];
            r_pval[k+1] <= r_pval[k];
        end
    end

    // ---------------- final: sign, offset, saturate, point-edge pick ----------------
    logic signed [RW-1:0]  n_q, n_sum;
    logic signed [VW-1:0]  n_res;
    logic                  n_clip;

    always_comb begin
        n_q   = r_ctl[QW].neg ? -RW'({1'b0, r_dq[QW]}) : RW'({1'b0, r_dq[QW]});
        n_sum = RW'(r_v2[QW]) + n_q;
        n_clip = 1'b0;
        n_res  = n_sum[VW-1:0];
        if (n_sum > VMAX) begin
            n_res  = VMAX[VW-1:0];
            n_clip = 1'b1;
        end else if (n_sum < VMIN) begin
            n_res  = VMIN[VW-1:0];
            n_clip = 1'b1;
        end
        if (r_ctl[QW].point) begin
            n_res  = r_pval[QW];
            n_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_ctl[QW].valid;
        end
        o_result_value <= n_res;
        o_point_edge   <= r_ctl[QW].point;
        o_clipped      <= n_clip;
    end

endmodule

`default_nettype wire

// ----- test/edge_attribute_interpolator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edge_attribute_interpolator_tb
// Drives edge/query items through the interpolator and checks each result
// strobe against a predicted value, point flag and saturation flag.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_attribute_interpolator_tb;

    localparam int CW = 13;
    localparam int VW = 24;
    localparam int LATENCY = CW + VW + 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM = 1830;

    typedef struct {
        logic signed [CW-1:0] ax, ay, bx, by, qx, qy;
        logic signed [VW-1:0] ad, bd, va, vb;
        int gap;
        bit drain;  // hold off until all results are back
    } t_edge_item;

    typedef struct {
        logic signed [VW-1:0] value;
        logic point;
        logic clip;
    } t_interp;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    logic signed [CW-1:0] i_a_x = 0, i_a_y = 0, i_b_x = 0, i_b_y = 0;
    logic signed [CW-1:0] i_query_x = 0, i_query_y = 0;
    logic signed [VW-1:0] i_a_depth = 0, i_b_depth = 0, i_value_a = 0, i_value_b = 0;
    logic o_done;
    logic signed [VW-1:0] o_result_value;
    logic o_point_edge;
    logic o_clipped;

    t_edge_item pending_items[$];
    t_interp    expected_interps[$];
    int  mismatches = 0;
    int  cycles = 0;
    bit  stimulus_done = 0;

    edge_attribute_interpolator #(.COORD_BITS(CW), .VALUE_BITS(VW)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_a_x(i_a_x), .i_a_y(i_a_y), .i_a_depth(i_a_depth),
        .i_b_x(i_b_x), .i_b_y(i_b_y), .i_b_depth(i_b_depth),
        .i_query_x(i_query_x), .i_query_y(i_query_y),
        .i_value_a(i_value_a), .i_value_b(i_value_b),
        .o_done(o_done), .o_result_value(o_result_value),
        .o_point_edge(o_point_edge), .o_clipped(o_clipped)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    function automatic t_interp interpolate_edge(t_edge_item it);
        t_interp r;
        longint x1, y1, x2, y2, v1, v2, t, dx, dy, span, offs, num, mag, q, res;
        longint vmax, vmin;
        vmax = (longint'(1) <<< (VW - 1)) - 1;
        vmin = -vmax - 1;
        x1 = it.ax; y1 = it.ay; x2 = it.bx; y2 = it.by;
        v1 = it.va; v2 = it.vb;
        r.point = 0;
        r.clip = 0;
        if (x1 == x2 && y1 == y2) begin
            r.value = (it.ad > it.bd) ? it.va : it.vb;
            r.point = 1;
            return r;
        end
        if (y1 > y2) begin
            t = x1; x1 = x2; x2 = t;
            t = y1; y1 = y2; y2 = t;
            t = v1; v1 = v2; v2 = t;
        end
        dx = x2 - x1;
        dy = y2 - y1;
        if (dx != 0 && (dy < 0 ? -dy : dy) < (dx < 0 ? -dx : dx)) begin
            if (x1 > x2) begin
                t = x1; x1 = x2; x2 = t;
                t = v1; v1 = v2; v2 = t;
            end
            span = x2 - x1;
            offs = x2 - longint'(it.qx);
        end else begin
            span = y2 - y1;
            offs = y2 - longint'(it.qy);
        end
        num = offs * (v1 - v2);
        mag = ((num < 0 ? -num : num) + span / 2) / span;
        q = (num < 0) ? -mag : mag;
        res = v2 + q;
        if (res > vmax) begin res = vmax; r.clip = 1; end
        if (res < vmin) begin res = vmin; r.clip = 1; end
        r.value = res[VW-1:0];
        return r;
    endfunction

    function automatic logic signed [CW-1:0] rand_coord();
        return CW'($urandom);
    endfunction

    function automatic logic signed [VW-1:0] rand_value();
        case ($urandom_range(0, 3))
            0: return VW'($urandom);
            1: return VW'($urandom_range(0, 2000)) - VW'(1000);
            default: return VW'($urandom_range(0, 1 << 20)) - VW'(1 << 19);
        endcase
    endfunction

    task automatic add_item(input logic signed [CW-1:0] ax, ay, bx, by, qx, qy,
                            input logic signed [VW-1:0] ad, bd, va, vb, input bit drain);
        t_edge_item it;
        it.ax = ax; it.ay = ay; it.bx = bx; it.by = by; it.qx = qx; it.qy = qy;
        it.ad = ad; it.bd = bd; it.va = va; it.vb = vb;
        it.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        it.drain = drain;
        pending_items.insert(pending_items.size(), it);
    endtask

    localparam logic signed [CW-1:0] CMIN = -(1 << (CW - 1));
    localparam logic signed [CW-1:0] CMAX = (1 << (CW - 1)) - 1;
    localparam logic signed [VW-1:0] VMIN = -(1 << (VW - 1));
    localparam logic signed [VW-1:0] VMAX = (1 << (VW - 1)) - 1;

    initial begin
        logic signed [CW-1:0] ax, ay, bx, by, qx, qy;
        int k;
        // same pixel, depth picks either side, and equal depths
        add_item(5, 5, 5, 5, 0, 0, 10, 3, 111, 222, 0);
        add_item(5, 5, 5, 5, 0, 0, 3, 10, 111, 222, 0);
        add_item(CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, 7, 7, VMIN, VMAX, 0);
        add_item(CMAX, CMIN, CMAX, CMIN, 0, 0, VMAX, VMIN, VMAX, VMIN, 0);
        // vertical, diagonal, x-major in both directions
        add_item(0, 0, 0, 10, 0, 4, 0, 0, 0, 2560, 0);
        add_item(0, 10, 0, 0, 0, 4, 0, 0, 0, 2560, 0);
        add_item(0, 0, 8, 8, 3, 3, 0, 0, 100, -100, 0);
        add_item(0, 0, 10, 3, 7, 0, 0, 0, 256, 512, 0);
        add_item(10, 0, 0, 3, 7, 0, 0, 0, 256, 512, 0);
        add_item(0, 0, -10, -3, -7, 0, 0, 0, -256, 512, 0);
        // rounding ties
        add_item(0, 0, 0, 2, 0, 1, 0, 0, 1, 0, 0);
        add_item(0, 0, 0, 2, 0, 1, 0, 0, -1, 0, 0);
        // extreme extrapolation both ways, saturating; full-range edges too
        add_item(0, 0, 0, 1, CMAX, CMIN, 0, 0, VMAX, VMIN, 0);
        add_item(0, 0, 0, 1, CMAX, CMIN, 0, 0, VMIN, VMAX, 0);
        add_item(CMIN, 0, CMAX, 0, CMIN, 0, 0, 0, VMAX, VMIN, 0);
        add_item(CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, VMIN, VMAX, VMIN, VMAX, 0);
        add_item(CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, 0, 0, VMAX, VMAX, 1);
        add_item(0, 0, 1, 0, -1, 0, 0, 0, VMAX, VMIN, 0);
        for (k = 0; k < N_RANDOM; k++) begin
            ax = rand_coord(); ay = rand_coord();
            case ($urandom_range(0, 5))
                0: begin bx = ax; by = ay; end
                1: begin
                    bx = ax + CW'($urandom_range(0, 40)) - CW'(20);
                    by = ay + CW'($urandom_range(0, 40)) - CW'(20);
                end
                2: begin bx = ax; by = rand_coord(); end
                default: begin bx = rand_coord(); by = rand_coord(); end
            endcase
            if ($urandom_range(0, 2) == 0) begin
                qx = rand_coord(); qy = rand_coord();
            end else begin
                // query near the edge mostly stays within range
                qx = ax + CW'($urandom_range(0, 64)) - CW'(32);
                qy = ay + CW'($urandom_range(0, 64)) - CW'(32);
            end
            add_item(ax, ay, bx, by, qx, qy, rand_value(), rand_value(),
                     rand_value(), rand_value(), (k % 600) == 599);
        end
        stimulus_done = 1;
    end

    task automatic drive_front();
        t_edge_item it;
        it = pending_items.pop_front();
        i_a_x <= it.ax; i_a_y <= it.ay; i_a_depth <= it.ad;
        i_b_x <= it.bx; i_b_y <= it.by; i_b_depth <= it.bd;
        i_query_x <= it.qx; i_query_y <= it.qy;
        i_value_a <= it.va; i_value_b <= it.vb;
        start <= 1;
    endtask

    // driver: start changes only at falling edges
    int  wait_cnt = -1;
    bit  holding = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 0;
        end else if (start && busy) begin
            // transfer not yet taken; hold
        end else if (pending_items.size() == 0) begin
            start <= 0;
        end else if (wait_cnt < 0) begin
            wait_cnt = pending_items[0].gap;
            holding = pending_items[0].drain;
            if (wait_cnt == 0 && !holding) begin
                wait_cnt = -1;
                drive_front();
            end else begin
                // this cycle already counts as idle
                if (wait_cnt > 0)
                    wait_cnt--;
                start <= 0;
            end
        end else if (holding && expected_interps.size() != 0) begin
            start <= 0;
        end else if (wait_cnt > 0) begin
            holding = 0;
            wait_cnt--;
            start <= 0;
        end else begin
            holding = 0;
            wait_cnt = -1;
            drive_front();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_interp exp_r;
        cycles <= cycles + 1;
        if (i_rst_n && start && !busy) begin
            t_edge_item it;
            it.ax = i_a_x; it.ay = i_a_y; it.ad = i_a_depth;
            it.bx = i_b_x; it.by = i_b_y; it.bd = i_b_depth;
            it.qx = i_query_x; it.qy = i_query_y;
            it.va = i_value_a; it.vb = i_value_b;
            expected_interps.insert(expected_interps.size(), interpolate_edge(it));
        end
        if (i_rst_n && o_done) begin
            if (expected_interps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: value %0d", o_result_value);
            end else begin
                exp_r = expected_interps.pop_front();
                if (o_result_value !== exp_r.value || o_point_edge !== exp_r.point ||
                    o_clipped !== exp_r.clip) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp value %0d point %0b clip %0b, got %0d %0b %0b",
                                 exp_r.value, exp_r.point, exp_r.clip,
                                 o_result_value, o_point_edge, o_clipped);
                end
            end
        end
    end

    initial begin
        int tail;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1;
        fork
            begin
                while (!(stimulus_done && pending_items.size() == 0 && !start))
                    @(posedge i_clk);
                while (expected_interps.size() != 0)
                    @(posedge i_clk);
                for (tail = 0; tail < LATENCY + 10; tail++) @(posedge i_clk);
                if (mismatches == 0 && expected_interps.size() == 0)
                    $display("SUCCESS");
                else
                    $display("FAILURE");
            end
            begin
                while (cycles < CYCLE_LIMIT)
                    @(posedge i_clk);
                $display("FAILURE");
            end
        join_any
        $finish;
    end

endmodule

`default_nettype wire
